[design/qpg_pkg.sv]
// ----------------------------------------------------------------------------
// qpg_pkg: shared types for the quad panel geometry pipeline
// Beat payloads and the vector element types used by the cross-product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qpg_pkg;

	// one input beat: the four panel corners, signed fixed point
	typedef struct packed {
		logic signed [31:0] c1_x;
		logic signed [31:0] c1_y;
		logic signed [31:0] c1_z;
		logic signed [31:0] c2_x;
		logic signed [31:0] c2_y;
		logic signed [31:0] c2_z;
		logic signed [31:0] c3_x;
		logic signed [31:0] c3_y;
		logic signed [31:0] c3_z;
		logic signed [31:0] c4_x;
		logic signed [31:0] c4_y;
		logic signed [31:0] c4_z;
	} panel_t;

	// one output beat
	typedef struct packed {
		logic        [39:0] panel_area;
		logic        [33:0] span_width;
		logic signed [31:0] colloc_x;
		logic signed [31:0] colloc_y;
		logic signed [31:0] colloc_z;
		logic signed [31:0] unit_nx;
		logic signed [31:0] unit_ny;
		logic signed [31:0] unit_nz;
		logic signed [31:0] vortex_start_x;
		logic signed [31:0] vortex_start_y;
		logic signed [31:0] vortex_start_z;
		logic               normal_degenerate;
	} geom_t;

	// difference of two coordinates
	typedef logic signed [32:0] s33_t;

	// magnitude of a cross-product component
	typedef logic [65:0] mag_t;

endpackage

`default_nettype wire

[design/quad_panel_geometry.sv]
// ----------------------------------------------------------------------------
// quad_panel_geometry: vortex lattice panel geometry pipeline
// Takes one panel (four 3-D corners) per beat and returns area, span width,
// collocation point, unit normal and quarter-chord vortex start point.
// ----------------------------------------------------------------------------
// Channels: the panel channel carries the twelve corner coordinates as one
// packed beat; the geom channel returns one result beat per panel, in order.
// Both use valid/ready and a beat moves when both are high.
// Throughput: one panel per cycle while the pipeline is not stalled. The
// longest path is the 66-stage square root of the area cross product; the
// normal runs a 32-stage root followed by a 31-stage divider in parallel,
// and shorter results ride delay lines.
// Stall: the whole pipeline advances as one; while a result sits unaccepted
// in the output stage, every stage holds and panel_ready is low. Nothing is
// lost or repeated; bubbles travel with their valid bits.
// Reset: arst_n clears the stage valid bits only; datapath registers are
// left as they are and are ignored until valid data reaches them.
// FRAC_BITS sets the fraction bits of the coordinates and scales the area.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_panel_geometry
	import qpg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   panel_valid,
	output logic   panel_ready,
	input  panel_t panel,
	output logic   geom_valid,
	input  logic   geom_ready,
	output geom_t  geom
);

	localparam int NSTG = 74;

	// ---------------------------------------------------------------- helpers
	function automatic logic [32:0] sx33(input logic [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic signed [35:0] sx36(input logic [31:0] v);
		return {{4{v[31]}}, v};
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		logic [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// bit length of one byte, 0 for zero
	function automatic logic [3:0] blen8(input logic [7:0] v);
		logic [3:0] r;
		r = '0;
		for (int b = 0; b < 8; b++) begin
			if (v[b]) begin
				r = 4'(b + 1);
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- control
	logic            en;
	logic [NSTG:1]   vld_s;

	// advance everything unless the output holds an untaken beat
	assign en          = !vld_s[NSTG] || geom_ready;
	assign panel_ready = en;
	assign geom_valid  = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], panel_valid};
		end
	end

	// ---------------------------------------------------------------- stage 1
	logic signed [31:0] crn [4][3];

	assign crn[0][0] = panel.c1_x;
	assign crn[0][1] = panel.c1_y;
	assign crn[0][2] = panel.c1_z;
	assign crn[1][0] = panel.c2_x;
	assign crn[1][1] = panel.c2_y;
	assign crn[1][2] = panel.c2_z;
	assign crn[2][0] = panel.c3_x;
	assign crn[2][1] = panel.c3_y;
	assign crn[2][2] = panel.c3_z;
	assign crn[3][0] = panel.c4_x;
	assign crn[3][1] = panel.c4_y;
	assign crn[3][2] = panel.c4_z;

	logic signed [35:0] rear_c [3];
	logic signed [35:0] csum_c [3];
	logic signed [35:0] vsum_c [3];
	logic        [31:0] cp_c   [3];
	logic        [31:0] vs_c   [3];

	// collocation point: floor((P1+P2+3P3+3P4+4)/8); vortex start:
	// floor((3P1+P4+2)/4). Both round half up.
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			rear_c[d] = sx36(crn[2][d]) + sx36(crn[3][d]);
			csum_c[d] = sx36(crn[0][d]) + sx36(crn[1][d]) + (rear_c[d] <<< 1) + rear_c[d]
				+ 36'sd4;
			vsum_c[d] = (sx36(crn[0][d]) <<< 1) + sx36(crn[0][d]) + sx36(crn[3][d]) + 36'sd2;
			cp_c[d]   = sat32(csum_c[d] >>> 3);
			vs_c[d]   = sat32(vsum_c[d] >>> 2);
		end
	end

	logic [31:0] p1_s1 [3];
	logic [31:0] p2_s1 [3];
	s33_t        d1_s1 [3];
	s33_t        d2_s1 [3];
	s33_t        sd_s1 [3];
	logic [31:0] cp_s1 [3];
	logic [31:0] vs_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				p1_s1[d] <= crn[0][d];
				p2_s1[d] <= crn[1][d];
				d1_s1[d] <= sx33(crn[2][d]) - sx33(crn[0][d]);
				d2_s1[d] <= sx33(crn[3][d]) - sx33(crn[1][d]);
				sd_s1[d] <= sx33(crn[1][d]) - sx33(crn[0][d]);
				cp_s1[d] <= cp_c[d];
				vs_s1[d] <= vs_c[d];
			end
		end
	end

	// ---------------------------------------------------------------- span
	logic signed [65:0] sdq [3];
	logic        [64:0] ssq_s2 [3];
	logic        [67:0] ssum_s3;
	logic        [33:0] span_root;
	logic        [33:0] span_s74;

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			sdq[d] = sd_s1[d] * sd_s1[d];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				ssq_s2[d] <= sdq[d][64:0];
			end
			ssum_s3 <= 68'(ssq_s2[0]) + 68'(ssq_s2[1]) + 68'(ssq_s2[2]);
		end
	end

	qpg_isqrt #(.W(68)) u_span_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (ssum_s3),
		.root     (span_root)
	);

	qpg_delay #(.W(34), .N(37)) u_span_dly (
		.clk (clk),
		.en  (en),
		.d   (span_root),
		.q   (span_s74)
	);

	// ---------------------------------------------------------------- area
	// |(P3-P1) x (P4-P2)|, each square split into 34/32-bit partial products
	mag_t         amag [3];
	logic [67:0]  hh_s5 [3];
	logic [65:0]  hl_s5 [3];
	logic [63:0]  ll_s5 [3];
	logic [131:0] asq_s6 [3];
	logic [131:0] asum_s7;
	logic [65:0]  aroot;
	logic [65:0]  ashr;
	logic [39:0]  area_s74;

	qpg_cross u_area_cross (
		.clk (clk),
		.en  (en),
		.a   (d1_s1),
		.b   (d2_s1),
		.mag (amag),
		.neg ()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				hh_s5[d]  <= amag[d][65:32] * amag[d][65:32];
				hl_s5[d]  <= amag[d][65:32] * amag[d][31:0];
				ll_s5[d]  <= amag[d][31:0] * amag[d][31:0];
				asq_s6[d] <= (132'(hh_s5[d]) << 64) + (132'(hl_s5[d]) << 33)
					+ 132'(ll_s5[d]);
			end
			asum_s7 <= asq_s6[0] + asq_s6[1] + asq_s6[2];
		end
	end

	qpg_isqrt #(.W(132)) u_area_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (asum_s7),
		.root     (aroot)
	);

	// halve and drop the fraction scaling, saturate to 40 bits
	assign ashr = aroot >> (FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			area_s74 <= (|ashr[65:40]) ? '1 : ashr[39:0];
		end
	end

	// ---------------------------------------------------------------- normal
	s33_t        e_s2 [3];
	s33_t        f_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				e_s2[d] <= sx33(cp_s1[d]) - sx33(p2_s1[d]);
				f_s2[d] <= sx33(cp_s1[d]) - sx33(p1_s1[d]);
			end
		end
	end

	mag_t        nmag [3];
	logic [2:0]  nneg;

	qpg_cross u_norm_cross (
		.clk (clk),
		.en  (en),
		.a   (e_s2),
		.b   (f_s2),
		.mag (nmag),
		.neg (nneg)
	);

	// leading-one search over the OR of the magnitudes, one byte per lane
	logic [71:0] nor_w;
	logic [8:0]  nz_c;
	logic [3:0]  sub_c [9];
	logic [8:0]  nz_s6;
	logic [3:0]  sub_s6 [9];
	mag_t        nmag_s6 [3];
	logic [2:0]  nneg_s6;

	always_comb begin
		nor_w = {6'b0, nmag[0] | nmag[1] | nmag[2]};
		for (int i = 0; i < 9; i++) begin
			nz_c[i]  = |nor_w[i*8 +: 8];
			sub_c[i] = blen8(nor_w[i*8 +: 8]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s6   <= nz_c;
			sub_s6  <= sub_c;
			nmag_s6 <= nmag;
			nneg_s6 <= nneg;
		end
	end

	logic [6:0] len_c;
	logic [6:0] len_s7;
	mag_t       nmag_s7 [3];
	logic [2:0] nneg_s7;

	always_comb begin
		len_c = '0;
		for (int i = 0; i < 9; i++) begin
			if (nz_s6[i]) begin
				len_c = 7'(i * 8) + {3'b000, sub_s6[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s7  <= len_c;
			nmag_s7 <= nmag_s6;
			nneg_s7 <= nneg_s6;
		end
	end

	// scale so the largest magnitude has exactly 31 significant bits
	mag_t        rsh [3];
	mag_t        lsh [3];
	logic [30:0] m_c [3];
	logic [30:0] m_s8 [3];
	logic        deg_s8;
	logic [2:0]  nneg_s8;

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			rsh[d] = nmag_s7[d] >> (len_s7 - 7'd31);
			lsh[d] = nmag_s7[d] << (7'd31 - len_s7);
			m_c[d] = (len_s7 > 7'd31) ? rsh[d][30:0] : lsh[d][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s8    <= m_c;
			deg_s8  <= (len_s7 == 7'd0);
			nneg_s8 <= nneg_s7;
		end
	end

	logic [61:0] msq_s9 [3];
	logic [63:0] msum_s10;
	logic [31:0] lroot;
	logic [31:0] lden;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 3; d++) begin
				msq_s9[d] <= m_s8[d] * m_s8[d];
			end
			msum_s10 <= 64'(msq_s9[0]) + 64'(msq_s9[1]) + 64'(msq_s9[2]);
		end
	end

	qpg_isqrt #(.W(64)) u_len_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (msum_s10),
		.root     (lroot)
	);

	// a zero length only comes with a degenerate normal; keep the divider sane
	assign lden = (lroot == '0) ? 32'd1 : lroot;

	logic [92:0] md;
	logic [30:0] md_u [3];
	logic [30:0] q_u  [3];
	logic [3:0]  flg_s73;

	qpg_delay #(.W(93), .N(34)) u_m_dly (
		.clk (clk),
		.en  (en),
		.d   ({m_s8[0], m_s8[1], m_s8[2]}),
		.q   (md)
	);

	assign md_u[0] = md[92:62];
	assign md_u[1] = md[61:31];
	assign md_u[2] = md[30:0];

	for (genvar d = 0; d < 3; d++) begin : g_div
		qpg_div #(.NW(61), .DW(32), .QW(31)) u_div (
			.clk  (clk),
			.en   (en),
			.num  ({md_u[d], 30'b0}),
			.den  (lden),
			.quot (q_u[d])
		);
	end

	qpg_delay #(.W(4), .N(65)) u_flg_dly (
		.clk (clk),
		.en  (en),
		.d   ({deg_s8, nneg_s8}),
		.q   (flg_s73)
	);

	// clamp to one, apply sign, zero a degenerate normal
	logic [30:0] qc  [3];
	logic [31:0] un_c [3];
	logic [31:0] un_s74 [3];
	logic        deg_s74;

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			qc[d]   = (q_u[d] > 31'h4000_0000) ? 31'h4000_0000 : q_u[d];
			un_c[d] = flg_s73[d] ? ('0 - {1'b0, qc[d]}) : {1'b0, qc[d]};
			if (flg_s73[3]) begin
				un_c[d] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			un_s74  <= un_c;
			deg_s74 <= flg_s73[3];
		end
	end

	// ---------------------------------------------------------------- points
	logic [191:0] cv_s74;

	qpg_delay #(.W(192), .N(73)) u_pt_dly (
		.clk (clk),
		.en  (en),
		.d   ({cp_s1[0], cp_s1[1], cp_s1[2], vs_s1[0], vs_s1[1], vs_s1[2]}),
		.q   (cv_s74)
	);

	// ---------------------------------------------------------------- output
	// flag order in the delay line: degenerate, then signs z, y, x
	assign geom.panel_area        = area_s74;
	assign geom.span_width        = span_s74;
	assign geom.colloc_x          = cv_s74[191:160];
	assign geom.colloc_y          = cv_s74[159:128];
	assign geom.colloc_z          = cv_s74[127:96];
	assign geom.unit_nx           = un_s74[0];
	assign geom.unit_ny           = un_s74[1];
	assign geom.unit_nz           = un_s74[2];
	assign geom.vortex_start_x    = cv_s74[95:64];
	assign geom.vortex_start_y    = cv_s74[63:32];
	assign geom.vortex_start_z    = cv_s74[31:0];
	assign geom.normal_degenerate = deg_s74;

endmodule

`default_nettype wire

[design/qpg_delay.sv]
// ----------------------------------------------------------------------------
// qpg_delay: pipeline delay line
// Holds side data for a fixed number of stages so it meets the long paths.
// ----------------------------------------------------------------------------
`default_nettype none

module qpg_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= d;
			for (int k = 1; k < N; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign q = dly_s[N-1];

endmodule

`default_nettype wire

[design/qpg_cross.sv]
// ----------------------------------------------------------------------------
// qpg_cross: three-stage cross product
// Multiply, subtract, then split each component into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module qpg_cross
	import qpg_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  s33_t       a   [3],
	input  s33_t       b   [3],
	output mag_t       mag [3],
	output logic [2:0] neg
);

	logic signed [65:0] pa_s1  [3];
	logic signed [65:0] pb_s1  [3];
	logic        [66:0] dif_s2 [3];
	logic        [66:0] ndif   [3];
	mag_t               mag_s3 [3];
	logic        [2:0]  neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= a[(i+1)%3] * b[(i+2)%3];
				pb_s1[i] <= a[(i+2)%3] * b[(i+1)%3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dif_s2[i] <= {pa_s1[i][65], pa_s1[i]} - {pb_s1[i][65], pb_s1[i]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ndif[i] = '0 - dif_s2[i];
		end
	end

	// negate where the sign is set; the magnitude always fits 66 bits
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= dif_s2[i][66];
				mag_s3[i] <= dif_s2[i][66] ? ndif[i][65:0] : dif_s2[i][65:0];
			end
		end
	end

	assign mag = mag_s3;
	assign neg = neg_s3;

endmodule

`default_nettype wire

[design/qpg_isqrt.sv]
// ----------------------------------------------------------------------------
// qpg_isqrt: pipelined integer square root
// One root bit per stage, restoring digit-by-digit method, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module qpg_isqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   radicand,
	output logic [W/2-1:0] root
);

	localparam int H  = W / 2;
	localparam int RW = H + 2;

	logic [W-1:0]  rad_s  [H];
	logic [RW-1:0] rem_s  [H];
	logic [H-1:0]  root_s [H];

	for (genvar k = 0; k < H; k++) begin : g_stg
		logic [W-1:0]  rad_in;
		logic [RW-1:0] rem_in;
		logic [H-1:0]  root_in;
		logic [RW+1:0] acc;
		logic [RW+1:0] trial;
		logic [RW+1:0] dif;
		logic          ge;

		if (k == 0) begin : g_head
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_tail
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign acc   = {rem_in, rad_in[W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign dif   = acc - trial;
		assign ge    = (acc >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_in[H-2:0], ge};
				rem_s[k]  <= ge ? dif[RW-1:0] : acc[RW-1:0];
				rad_s[k]  <= rad_in << 2;
			end
		end
	end

	assign root = root_s[H-1];

endmodule

`default_nettype wire

[design/qpg_div.sv]
// ----------------------------------------------------------------------------
// qpg_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qpg_div #(
	parameter int NW = 61,
	parameter int DW = 32,
	parameter int QW = 31
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] nb_s  [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] nb_in;
		logic [QW-1:0] quo_in;
		logic [DW:0]   acc;
		logic [DW:0]   dif;
		logic          ge;

		if (k == 0) begin : g_head
			assign rem_in = DW'(num[NW-1:QW]);
			assign den_in = den;
			assign nb_in  = num[QW-1:0];
			assign quo_in = '0;
		end else begin : g_tail
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign nb_in  = nb_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign acc = {rem_in, nb_in[QW-1]};
		assign dif = acc - {1'b0, den_in};
		assign ge  = (acc >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? dif[DW-1:0] : acc[DW-1:0];
				den_s[k] <= den_in;
				nb_s[k]  <= nb_in << 1;
				quo_s[k] <= {quo_in[QW-2:0], ge};
			end
		end
	end

	assign quot = quo_s[QW-1];

endmodule

`default_nettype wire
